>>> src/twm_pkg.sv
// twm_pkg: shared constants, field widths and a helper function for the
// windowed throughput meter. No dependencies.
package twm_pkg;

    localparam int MAX_BUCKETS_DEF = 64;

    localparam int DATA_W  = 48;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 20;
    localparam int SPAN_W  = 7;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 7'd8;
    localparam logic [DATA_W-1:0] DATA_MAX   = {DATA_W{1'b1}};

    localparam logic MODE_TRANSFER = 1'b0;
    localparam logic MODE_QUERY    = 1'b1;

    // saturating add of a byte count onto a 48-bit accumulator
    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {{(DATA_W+1-COUNT_W){1'b0}}, b};
        return s[DATA_W] ? DATA_MAX : s[DATA_W-1:0];
    endfunction

endpackage

>>> src/windowed_throughput_meter_unit.sv
// windowed_throughput_meter_unit: top level, sequencer around the shared divider
// and the bucket RAM. Depends on twm_pkg, twm_ram, twm_div.
//
// Input stream: tuser is the mode (0 record a transfer, 1 query the window
// average), tdata carries now_seconds and byte_count. Output stream: one
// result per input item, tdata carries average_rate and current_rate.
// The config channel writes window_span and is always ready; write it only
// while no item is in flight.
// A transfer runs the bit-serial divider to compute the bucket index
// (now_seconds modulo the span), then reads and updates that bucket.
// A query walks the bucket RAM over the span (one read per cycle), then
// runs the same divider for the average when an older bucket qualified.
// One item is in flight at a time; input tready is low while it works.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the block stalls at the end of that item only if the
// earlier result is still not taken.
// Reset (synchronous, active low) clears all bucket valid bits, the decaying
// and captured rates, the last decay second, and sets window_span to 8.
module windowed_throughput_meter_unit #(
    parameter int MAX_BUCKETS = twm_pkg::MAX_BUCKETS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // now_seconds[31:0], byte_count[51:32], zero pad
    input  logic        i_s_axis_tuser,   // mode[0]
    // stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // average_rate[47:0], current_rate[95:48]
    // config
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    localparam int DATA_W  = twm_pkg::DATA_W;
    localparam int STAMP_W = twm_pkg::STAMP_W;
    localparam int COUNT_W = twm_pkg::COUNT_W;
    localparam int CFG_W   = twm_pkg::SPAN_W;
    localparam int IDX_W   = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
    localparam int SPAN_W  = $clog2(MAX_BUCKETS + 1);
    localparam int EXT_W   = SPAN_W > CFG_W ? SPAN_W : CFG_W;
    localparam int SUM_W   = DATA_W + SPAN_W;
    localparam int ENTRY_W = STAMP_W + DATA_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MOD   = 9'b000000010,
        S_RDW   = 9'b000000100,
        S_UPD   = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_DIVGO = 9'b001000000,
        S_QDIV  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_span;
    logic [MAX_BUCKETS-1:0] r_valid;
    logic               r_mode;
    logic [STAMP_W-1:0] r_now;
    logic [COUNT_W-1:0] r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_pidx;
    logic               r_pend;
    logic [SUM_W-1:0]   r_sum;
    logic [STAMP_W-1:0] r_oldest;
    logic [DATA_W-1:0]  r_res_avg;
    logic [DATA_W-1:0]  r_decay;
    logic [DATA_W-1:0]  r_captured;
    logic [STAMP_W-1:0] r_last;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_avg;
    logic [DATA_W-1:0]  r_out_cur;

    logic [SPAN_W-1:0]  eff_span;
    logic [EXT_W-1:0]   span_ext;
    logic               s_acc;
    logic               in_mode;
    logic [STAMP_W-1:0] in_now;
    logic [COUNT_W-1:0] in_count;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [SPAN_W-1:0]  div_divisor;
    logic               div_done;
    logic [SUM_W-1:0]   div_quo;
    logic [SPAN_W-1:0]  div_rem;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [STAMP_W-1:0] rd_stamp;
    logic [DATA_W-1:0]  rd_total;

    logic               same_bucket;
    logic [DATA_W-1:0]  new_total;
    logic [STAMP_W-1:0] elapsed;
    logic [DATA_W-1:0]  decayed;
    logic               qualify;
    logic               out_load;

    assign in_mode  = i_s_axis_tuser;
    assign in_now   = i_s_axis_tdata[31:0];
    assign in_count = i_s_axis_tdata[51:32];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // clamp span into 1..MAX_BUCKETS
    assign span_ext = EXT_W'(r_span);
    always_comb begin
        if (r_span == '0) begin
            eff_span = SPAN_W'(1);
        end else if (span_ext > EXT_W'(MAX_BUCKETS)) begin
            eff_span = SPAN_W'(MAX_BUCKETS);
        end else begin
            eff_span = span_ext[SPAN_W-1:0];
        end
    end

    // divider: modulo for a transfer, average for a query
    always_comb begin
        div_start    = 1'b0;
        div_dividend = SUM_W'(in_now);
        div_divisor  = eff_span;
        if (s_acc && in_mode == twm_pkg::MODE_TRANSFER) begin
            div_start = 1'b1;
        end else if (r_state == S_DIVGO && r_oldest < r_now) begin
            div_start    = 1'b1;
            div_dividend = r_sum;
            div_divisor  = SPAN_W'(r_now - r_oldest);
        end
    end

    twm_div #(
        .DW (SUM_W),
        .VW (SPAN_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign ram_raddr = (r_state == S_SCAN) ? r_cnt : r_idx;
    assign rd_stamp  = ram_rdata[ENTRY_W-1:DATA_W];
    assign rd_total  = ram_rdata[DATA_W-1:0];

    assign same_bucket = r_valid[r_idx] && (rd_stamp == r_now);
    assign new_total   = twm_pkg::sat_add(same_bucket ? rd_total : '0, r_count);
    assign ram_we      = (r_state == S_UPD);
    assign ram_wdata   = {r_now, new_total};

    twm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // halving once per elapsed second, gone after 48
    assign elapsed = r_now - r_last;
    assign decayed = (elapsed >= STAMP_W'(DATA_W)) ? '0 : (r_decay >> elapsed[5:0]);

    assign qualify = r_valid[r_pidx]
                  && ({1'b0, rd_stamp} + (STAMP_W+1)'(eff_span) >= {1'b0, r_now})
                  && (rd_stamp < r_now);

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = (in_mode == twm_pkg::MODE_TRANSFER) ? S_MOD : S_SCAN;
                end
            end
            S_MOD: begin
                if (div_done) n_state = S_RDW;
            end
            S_RDW:   n_state = S_UPD;
            S_UPD:   n_state = S_DONE;
            S_SCAN: begin
                if (r_cnt == IDX_W'(eff_span - SPAN_W'(1))) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_DIVGO;
            S_DIVGO: n_state = (r_oldest < r_now) ? S_QDIV : S_DONE;
            S_QDIV: begin
                if (div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_span      <= twm_pkg::SPAN_RESET;
            r_valid     <= '0;
            r_decay     <= '0;
            r_captured  <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_span <= i_cfg_data;
            end
            if (r_state == S_UPD) begin
                r_valid[r_idx] <= 1'b1;
                if (r_now > r_last) begin
                    r_captured <= decayed;
                    r_last     <= r_now;
                    r_decay    <= twm_pkg::sat_add(decayed, r_count);
                end else begin
                    r_decay    <= twm_pkg::sat_add(r_decay, r_count);
                end
            end
            r_pend <= (r_state == S_SCAN);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_mode   <= in_mode;
            r_now    <= in_now;
            r_count  <= in_count;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_oldest <= in_now;
        end
        if (r_state == S_MOD && div_done) begin
            r_idx <= div_rem[IDX_W-1:0];
        end
        if (r_state == S_SCAN) begin
            r_pidx <= r_cnt;
            r_cnt  <= r_cnt + IDX_W'(1);
        end
        if (r_pend && qualify) begin
            r_sum <= r_sum + SUM_W'(rd_total);
            if (rd_stamp < r_oldest) r_oldest <= rd_stamp;
        end
        if (r_state == S_UPD || r_state == S_DIVGO) begin
            r_res_avg <= '0;
        end
        if (r_state == S_QDIV && div_done) begin
            r_res_avg <= (|div_quo[SUM_W-1:DATA_W]) ? twm_pkg::DATA_MAX
                                                    : div_quo[DATA_W-1:0];
        end
        if (out_load) begin
            r_out_avg <= (r_mode == twm_pkg::MODE_QUERY) ? r_res_avg : '0;
            r_out_cur <= r_captured;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_cur, r_out_avg};

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_axis_tready)
        else $error("input accepted again while an item is in flight");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MOD || r_state == S_QDIV))
        else $error("divider finished outside a divide state");

    a_scan_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (SPAN_W'(r_cnt) < eff_span))
        else $error("bucket scan ran past the window span");

    a_load_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_m_axis_tvalid && o_s_axis_tready))
        else $error("result load did not present output and free the input");
`endif

endmodule

>>> src/twm_ram.sv
// twm_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module twm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/twm_div.sv
// twm_div: iterative restoring divider, one quotient bit per cycle.
// Shared between the bucket index (modulo) and the window average. No dependencies.
module twm_div #(
    parameter int DW = 55,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;

    logic [VW:0]   trial;
    logic [VW+1:0] diff;
    logic          ge;

    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_div};
    assign ge    = !diff[VW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule
